// ===== hdl/eil4hp_pkg.sv =====
// Shared types and constants for the Ethernet / IP / L4 header parser.
// No dependencies; imported by every module of the parser.
`timescale 1ns / 1ps

package eil4hp_pkg;

    localparam logic [15:0] KIND_VLAN = 16'h8100;
    localparam logic [15:0] KIND_IPV4 = 16'h0800;
    localparam logic [15:0] KIND_IPV6 = 16'h86DD;
    localparam logic [7:0]  PROTO_TCP = 8'd6;
    localparam logic [7:0]  PROTO_UDP = 8'd17;

    localparam logic [6:0] L2_PLAIN    = 7'd14;
    localparam logic [6:0] L2_TAGGED   = 7'd18;
    localparam logic [6:0] KIND_LO_POS = 7'd13;  // last ethertype byte, untagged
    localparam logic [6:0] KIND_LO_TAG = 7'd17;  // last ethertype byte, tagged
    localparam logic [5:0] IPV6_HDR    = 6'd40;
    localparam logic [5:0] UDP_HDR     = 6'd8;
    localparam logic [6:0] IPV4_PROTO_OFS = 7'd9;
    localparam logic [6:0] IPV6_NXT_OFS   = 7'd6;
    localparam logic [6:0] TCP_OFS_OFS    = 7'd12;
    localparam logic [6:0] COUNT_MAX      = 7'd127;

    // Per-frame capture state
    typedef struct packed {
        logic [15:0] kind;
        logic        vlan;
        logic [7:0]  proto;
        logic [5:0]  ip_bytes;
        logic [5:0]  tcp_bytes;
        logic [6:0]  l4_start;
    } t_frame_state;

    // Result item, first field in the highest bits
    typedef struct packed {
        logic       truncated;
        logic       headers_found;
        logic [5:0] l4_length;
        logic [5:0] l3_length;
        logic [4:0] l2_length;
        logic [7:0] ip_proto;
        logic       is_ipv6;
        logic [15:0] ether_kind;
    } t_result;

endpackage

// ===== hdl/eil4hp_capture.sv =====
// Byte position tracking and header field capture, one byte per cycle while i_take is high.
// Depends on eil4hp_pkg.
`timescale 1ns / 1ps

module eil4hp_capture import eil4hp_pkg::*; #(
    parameter int POSITION_LIMIT = 127
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_take,
    input  logic [7:0]   i_byte,
    input  logic         i_last,
    output t_frame_state o_next,
    output logic [6:0]   o_count
);

    localparam int PW = $clog2(POSITION_LIMIT + 1);
    localparam logic [PW-1:0] POS_MAX  = PW'(POSITION_LIMIT);
    localparam logic [PW-1:0] POS_K_HI = PW'(12);
    localparam logic [PW-1:0] POS_K_LO = PW'(13);
    localparam logic [PW-1:0] POS_T_HI = PW'(16);
    localparam logic [PW-1:0] POS_T_LO = PW'(17);
    localparam logic [PW-1:0] POS_CLAMP = PW'(126);

    logic [PW-1:0] r_pos, n_pos;
    t_frame_state  r_st, n_st;
    logic [15:0]   kind_join;
    logic [6:0]    l3_start;
    logic [5:0]    ihl_bytes;
    logic          is_ip;

    always_comb begin
        n_st      = r_st;
        kind_join = {r_st.kind[15:8], i_byte};
        l3_start  = r_st.vlan ? L2_TAGGED : L2_PLAIN;
        ihl_bytes = {i_byte[3:0], 2'b00};
        is_ip     = (r_st.kind == KIND_IPV4) || (r_st.kind == KIND_IPV6);

        // Ethertype, with one VLAN tag skipped
        if (r_pos == POS_K_HI) begin
            n_st.kind = {i_byte, 8'h00};
        end else if (r_pos == POS_K_LO) begin
            if (kind_join == KIND_VLAN) begin
                n_st.vlan = 1'b1;
                n_st.kind = 16'h0000;
            end else begin
                n_st.kind = kind_join;
            end
        end else if (r_st.vlan && r_pos == POS_T_HI) begin
            n_st.kind = {i_byte, 8'h00};
        end else if (r_st.vlan && r_pos == POS_T_LO) begin
            n_st.kind = kind_join;
        end

        // L3 header; kind is settled before the L3 start byte
        if (r_st.kind == KIND_IPV4) begin
            if (r_pos == PW'(l3_start)) begin
                n_st.ip_bytes = ihl_bytes;
                n_st.l4_start = l3_start + {1'b0, ihl_bytes};
            end else if (r_pos == PW'(l3_start + IPV4_PROTO_OFS)) begin
                n_st.proto = i_byte;
            end
        end else if (r_st.kind == KIND_IPV6) begin
            if (r_pos == PW'(l3_start)) begin
                n_st.ip_bytes = IPV6_HDR;
                n_st.l4_start = l3_start + {1'b0, IPV6_HDR};
            end else if (r_pos == PW'(l3_start + IPV6_NXT_OFS)) begin
                n_st.proto = i_byte;
            end
        end

        // TCP data offset byte
        if (is_ip && r_st.ip_bytes != 6'd0 && r_st.proto == PROTO_TCP &&
            r_pos == PW'(r_st.l4_start + TCP_OFS_OFS)) begin
            n_st.tcp_bytes = {i_byte[7:4], 2'b00};
        end
    end

    always_comb begin
        n_pos = (r_pos < POS_MAX) ? r_pos + PW'(1) : r_pos;
        // frame length, clamped; every needed position lies far below the clamp
        o_count = (r_pos >= POS_CLAMP) ? COUNT_MAX : r_pos[6:0] + 7'd1;
        o_next  = n_st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_st  <= '0;
        end else if (i_take) begin
            if (i_last) begin
                r_pos <= '0;
                r_st  <= '0;
            end else begin
                r_pos <= n_pos;
                r_st  <= n_st;
            end
        end
    end

    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && i_last |=> r_pos == '0 && r_st == '0)
        else $error("frame state not cleared after frame end");

    a_pos_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_MAX)
        else $error("byte position beyond limit");

    a_tcp_after_ip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.tcp_bytes != 6'd0 |-> r_st.ip_bytes != 6'd0)
        else $error("TCP length captured without IP header length");

endmodule

// ===== hdl/eil4hp_result.sv =====
// Result assembly at frame end: lengths, protocol and truncation check.
// Depends on eil4hp_pkg.
`timescale 1ns / 1ps

module eil4hp_result import eil4hp_pkg::*; (
    input  t_frame_state i_st,
    input  logic [6:0]   i_count,
    output t_result      o_res
);

    logic [6:0] l3_start;
    logic [6:0] need;
    logic [6:0] tcp_need;
    logic [5:0] l3_len;
    logic [5:0] l4_len;
    logic [7:0] proto;
    logic       is6;
    logic       trunc;

    always_comb begin
        l3_start = i_st.vlan ? L2_TAGGED : L2_PLAIN;
        need     = i_st.vlan ? KIND_LO_TAG : KIND_LO_POS;
        tcp_need = i_st.l4_start + TCP_OFS_OFS;
        l3_len   = 6'd0;
        l4_len   = 6'd0;
        proto    = 8'd0;
        is6      = 1'b0;

        if (i_st.kind == KIND_IPV4) begin
            l3_len = i_st.ip_bytes;
            proto  = i_st.proto;
            need   = l3_start + IPV4_PROTO_OFS;
        end else if (i_st.kind == KIND_IPV6) begin
            is6    = 1'b1;
            l3_len = IPV6_HDR;
            proto  = i_st.proto;
            need   = l3_start + IPV6_NXT_OFS;
        end

        if (l3_len != 6'd0) begin
            if (proto == PROTO_TCP) begin
                l4_len = i_st.tcp_bytes;
                if (tcp_need > need) begin
                    need = tcp_need;
                end
            end else if (proto == PROTO_UDP) begin
                l4_len = UDP_HDR;
            end
        end
        trunc = need >= i_count;

        o_res = '0;
        if (i_count < L2_PLAIN) begin
            // runt frame: everything zero but truncated
            o_res.truncated = 1'b1;
        end else begin
            o_res.ether_kind    = i_st.kind;
            o_res.is_ipv6       = is6;
            o_res.ip_proto      = proto;
            o_res.l2_length     = l3_start[4:0];
            o_res.l3_length     = l3_len;
            o_res.l4_length     = l4_len;
            o_res.headers_found = !trunc && l3_len != 6'd0 && l4_len != 6'd0;
            o_res.truncated     = trunc;
        end
    end

endmodule

// ===== hdl/ethernet_ip_l4_header_parser_core.sv =====
// Ethernet / VLAN / IPv4 / IPv6 / TCP / UDP header length parser, top level.
// Latency: result valid the cycle after the transaction carrying tlast.
// Throughput: one byte per cycle while the result output is not stalled, no bubbles between frames.
// Reset: synchronous active-low; clears position, captured fields, output valid.
// Depends on eil4hp_pkg, eil4hp_capture, eil4hp_result.
`timescale 1ns / 1ps

module ethernet_ip_l4_header_parser_core import eil4hp_pkg::*; #(
    parameter int POSITION_LIMIT = 127
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] frame_byte
    input  logic        s_axis_tlast,   // frame_end
    // one result per frame
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // [15:0] ether_kind, [16] is_ipv6,
                                        // [24:17] ip_proto, [29:25] l2_length,
                                        // [35:30] l3_length, [41:36] l4_length,
                                        // [42] headers_found, [43] truncated,
                                        // [47:44] zero
);

    t_frame_state next_st;
    t_result      res_comb;
    t_result      r_res;
    logic         r_valid, n_valid;
    logic [6:0]   byte_count;
    logic         accept;

    // Output register frees up the same cycle it is taken, so a frame end can
    // land on top of a departing result.
    assign s_axis_tready = !r_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    eil4hp_capture #(
        .POSITION_LIMIT(POSITION_LIMIT)
    ) u_capture (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (accept),
        .i_byte  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .o_next  (next_st),
        .o_count (byte_count)
    );

    // Result built from the state as updated by the last byte
    eil4hp_result u_result (
        .i_st    (next_st),
        .i_count (byte_count),
        .o_res   (res_comb)
    );

    always_comb begin
        if (accept && s_axis_tlast) begin
            n_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept && s_axis_tlast) begin
            r_res <= res_comb;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {4'b0000, r_res};

    a_result_follows_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && s_axis_tlast |=> m_axis_tvalid)
        else $error("frame end did not produce a result");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a pending result");

    a_found_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_res.headers_found |->
            !r_res.truncated && r_res.l2_length != 5'd0 && r_res.l4_length != 6'd0)
        else $error("headers_found with incomplete header info");

endmodule
